### rtl/core/glucose_insulin_compartment_step_unit_defines.svh
// Assertion macros for the compartment step unit; they expect clk and arst_n in scope.
`ifndef GLUCOSE_INSULIN_COMPARTMENT_STEP_UNIT_DEFINES_SVH
`define GLUCOSE_INSULIN_COMPARTMENT_STEP_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GIC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GIC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/gic_pkg.sv
package gic_pkg;

	localparam int DEF_FRAC_BITS   = 16;
	localparam int DEF_STATE_WIDTH = 32;

	localparam int RATE_W    = 16;
	localparam int DOSE_W    = 16;
	localparam int DOSE_FRAC = 8;
	localparam int RND_W     = 32;
	localparam int MMOL_W    = 28;
	localparam int GRAMS_W   = 6;
	localparam int ELAPSED_W = 32;
	localparam int WAIT_W    = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_TRANSFER       = 3'd0,
		CFG_RATE_INSULIN_ACTION = 3'd1,
		CFG_RATE_INSULIN_DECAY  = 3'd2,
		CFG_RATE_ABSORPTION     = 3'd3,
		CFG_RATE_GUT            = 3'd4,
		CFG_RATE_EMPTYING       = 3'd5,
		CFG_GLUCOSE_THRESHOLD   = 3'd6
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] RST_RATE_TRANSFER       = 16'd26214;
	localparam logic [CFG_DATA_W-1:0] RST_RATE_INSULIN_ACTION = 16'd39322;
	localparam logic [CFG_DATA_W-1:0] RST_RATE_INSULIN_DECAY  = 16'd19661;
	localparam logic [CFG_DATA_W-1:0] RST_RATE_ABSORPTION     = 16'd22938;
	localparam logic [CFG_DATA_W-1:0] RST_RATE_GUT            = 16'd26214;
	localparam logic [CFG_DATA_W-1:0] RST_RATE_EMPTYING       = 16'd66;
	localparam logic [CFG_DATA_W-1:0] RST_GLUCOSE_THRESHOLD   = 16'd250;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_DOSE = 1'b1;

	localparam int DOSE_SCALE   = 50;
	localparam int TICK_MINUTES = 5;
	localparam int MEAL_MOD     = 56;
	localparam int MEAL_BASE    = 5;
	localparam int WAIT_MOD     = 121;
	localparam int WAIT_BASE    = 120;
	localparam int WAIT_RST     = 20;
	localparam int WAIT_R8      = 256 % WAIT_MOD;
	localparam int WAIT_R16     = (WAIT_R8 * WAIT_R8) % WAIT_MOD;

	localparam int MMOL_MUL         = 1000;
	localparam int MMOL_DIV         = 18018;
	localparam int MMOL_IN_W        = 33;
	localparam int MMOL_RECIP_SHIFT = 34;
	localparam int MMOL_RECIP_W     = 30;
	localparam logic [MMOL_RECIP_W-1:0] MMOL_RECIP = MMOL_RECIP_W'(
		((64'd1 << MMOL_RECIP_SHIFT) * 64'(MMOL_MUL)) / 64'(MMOL_DIV));
	localparam int MMOL_SAT_W = 34;
	localparam logic [MMOL_SAT_W-1:0] MMOL_SAT_G = MMOL_SAT_W'(
		((64'd1 << MMOL_W) * 64'(MMOL_DIV) + 64'(MMOL_MUL) - 64'd1) / 64'(MMOL_MUL));

	typedef struct packed {
		logic              command;
		logic [DOSE_W-1:0] dose_units;
		logic [RND_W-1:0]  random_word;
	} in_item_t;

	typedef struct packed {
		logic [MMOL_W-1:0]    glucose_mmol;
		logic [GRAMS_W-1:0]   meal_grams;
		logic [ELAPSED_W-1:0] elapsed_minutes;
	} out_item_t;

	typedef struct packed {
		logic [GRAMS_W-1:0]   meal_grams;
		logic [ELAPSED_W-1:0] elapsed_minutes;
	} res_side_t;

	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

### rtl/core/gic_mmol_pipe.sv
module gic_mmol_pipe #(
	parameter int STATE_WIDTH = gic_pkg::DEF_STATE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gic_pkg::pipe_ctl_t       ctl,
	input  logic [STATE_WIDTH-1:0]   glucose,
	input  gic_pkg::res_side_t       side,
	output logic                     result_valid,
	output gic_pkg::out_item_t       result
);

	localparam int GW    = (STATE_WIDTH > gic_pkg::MMOL_SAT_W) ? STATE_WIDTH
		: gic_pkg::MMOL_SAT_W;
	localparam int GC_W  = gic_pkg::MMOL_IN_W;
	localparam int LO_W  = 16;
	localparam int HI_W  = GC_W - LO_W;
	localparam int RW    = gic_pkg::MMOL_RECIP_W;
	localparam int SUM_W = GC_W + RW + 1;
	localparam int NM_W  = GC_W + 11;
	localparam int QW    = gic_pkg::MMOL_W;

	logic [GC_W-1:0]      gc;
	logic                 sat;
	logic [SUM_W-1:0]     sum;
	logic [NM_W-1:0]      rem;
	logic [QW-1:0]        q_fix;

	logic                 v_s1, v_s2, v_s3, result_valid_q;
	logic                 sat_s1, sat_s2, sat_s3;
	logic [GC_W-1:0]      gc_s1, gc_s2;
	logic [LO_W+RW-1:0]   plo_s1;
	logic [HI_W+RW-1:0]   phi_s1;
	logic [QW-1:0]        qest_s2, qest_s3;
	logic [NM_W-1:0]      n_s3, m_s3;
	gic_pkg::res_side_t   side_s1, side_s2, side_s3;
	gic_pkg::out_item_t   result_q;

	assign gc  = GC_W'(glucose);
	assign sat = GW'(glucose) >= GW'(gic_pkg::MMOL_SAT_G);
	assign sum = SUM_W'({phi_s1, {LO_W{1'b0}}}) + SUM_W'(plo_s1);
	assign rem = n_s3 - m_s3;
	assign q_fix = qest_s3 + QW'(rem >= NM_W'(gic_pkg::MMOL_DIV));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (ctl.en) begin
			v_s1           <= ctl.valid;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			result_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sat_s1  <= sat;
			gc_s1   <= gc;
			side_s1 <= side;
			plo_s1  <= (LO_W+RW)'(gc[LO_W-1:0]) * (LO_W+RW)'(gic_pkg::MMOL_RECIP);
			phi_s1  <= (HI_W+RW)'(gc[GC_W-1:LO_W]) * (HI_W+RW)'(gic_pkg::MMOL_RECIP);

			sat_s2  <= sat_s1;
			gc_s2   <= gc_s1;
			side_s2 <= side_s1;
			qest_s2 <= sum[gic_pkg::MMOL_RECIP_SHIFT +: QW];

			sat_s3  <= sat_s2;
			side_s3 <= side_s2;
			qest_s3 <= qest_s2;
			n_s3    <= NM_W'(gc_s2) * NM_W'(gic_pkg::MMOL_MUL);
			m_s3    <= NM_W'(qest_s2) * NM_W'(gic_pkg::MMOL_DIV);

			result_q.glucose_mmol    <= sat_s3 ? '1 : q_fix;
			result_q.meal_grams      <= side_s3.meal_grams;
			result_q.elapsed_minutes <= side_s3.elapsed_minutes;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/core/glucose_insulin_compartment_step_unit.sv
// Glucose/insulin compartment step unit.
// Item channel (item_valid, item_stall, item): each transaction is one command.
// A tick advances the seven compartments by one 5-minute Euler step and may add
// a meal; a dose adds 50 times the dose to subcutaneous insulin.
// Result channel (result_valid, result_stall, result): one transaction per item,
// in order, with plasma glucose in mmol/L, meal grams and elapsed minutes.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while no item is in flight. Unknown indexes are dropped.
// The unit takes one item per cycle while the result channel is not stalled.
// The state update is combinational logic (seven 16 x STATE_WIDTH products in
// parallel); the mmol conversion behind it is a four-stage constant divider.
// Reset clears all compartments and elapsed time, loads the meal wait with 20
// minutes, restores the register defaults and empties the pipeline.
// While result_valid is high and result_stall is high, the whole pipeline holds
// and item_stall is raised; with an empty output register it keeps moving.
`include "glucose_insulin_compartment_step_unit_defines.svh"

module glucose_insulin_compartment_step_unit #(
	parameter int FRAC_BITS   = gic_pkg::DEF_FRAC_BITS,
	parameter int STATE_WIDTH = gic_pkg::DEF_STATE_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  gic_pkg::in_item_t                  item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output gic_pkg::out_item_t                 result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gic_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gic_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int W      = STATE_WIDTH;
	localparam int SW     = STATE_WIDTH + 3;
	localparam int RW     = gic_pkg::RATE_W;
	localparam int CW     = (STATE_WIDTH > FRAC_BITS + RW) ? STATE_WIDTH : FRAC_BITS + RW;
	localparam int DPW    = gic_pkg::DOSE_W + 6;
	localparam int ADD_W  = DPW + FRAC_BITS - gic_pkg::DOSE_FRAC;
	localparam int AW     = ((STATE_WIDTH > ADD_W) ? STATE_WIDTH : ADD_W) + 1;
	localparam int GR_W   = gic_pkg::GRAMS_W;
	localparam int WT_W   = gic_pkg::WAIT_W;
	localparam int EL_W   = gic_pkg::ELAPSED_W;
	localparam logic [W-1:0] STATE_MAX = '1;

	function automatic logic [W-1:0] prod(input logic [RW-1:0] r, input logic [W-1:0] x);
		logic [W+RW-1:0] p;
		p = (W+RW)'(r) * (W+RW)'(x);
		return p[W+RW-1:RW];
	endfunction

	function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
		return $signed({3'b000, v});
	endfunction

	function automatic logic [W-1:0] clamp(input logic signed [SW-1:0] v);
		if (v < 0)
			return '0;
		else if (|v[SW-2:W])
			return STATE_MAX;
		else
			return v[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [ADD_W-1:0] b);
		logic [AW-1:0] s;
		s = AW'(a) + AW'(b);
		if (s > AW'(STATE_MAX))
			return STATE_MAX;
		else
			return s[W-1:0];
	endfunction

	logic en;

	logic [RW-1:0] rate_transfer_q, rate_action_q, rate_decay_q, rate_absorption_q;
	logic [RW-1:0] rate_gut_q, rate_emptying_q, threshold_q;

	logic [W-1:0]    plasma_glucose_q, tissue_glucose_q, plasma_insulin_q, insulin_effect_q;
	logic [W-1:0]    subcut_insulin_q, gut_first_q, gut_second_q;
	logic [EL_W-1:0] elapsed_q;
	logic [WT_W-1:0] wait_q;

	logic                v_s1, v_s2, v_s3;
	gic_pkg::in_item_t   item_s1;
	logic                cmd_s2;
	logic [GR_W-1:0]     grams_s2, grams_s3;
	logic [WT_W-1:0]     wait_s2;
	logic [ADD_W-1:0]    dose_add_s2;

	logic [7:0]          m8;
	logic [14:0]         y1;
	logic [10:0]         y2;
	logic [8:0]          y3;
	logic [GR_W-1:0]     grams_p;
	logic [WT_W-1:0]     wait_p;
	logic [ADD_W-1:0]    dose_add_p;

	logic [W-1:0]          diff, xfer_mag, act_x, gut_d1, gut_d2, dec_i, abs_s, loss;
	logic signed [SW-1:0]  xfer;
	logic                  above, meal_due, step, tick;
	logic [W-1:0]          g_n, t_n, i_n, x_n, s_n, d1_tick, d1_n, d2_n, s_dose;

	gic_pkg::pipe_ctl_t  mmol_ctl;
	gic_pkg::res_side_t  mmol_side;

	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_transfer_q   <= gic_pkg::RST_RATE_TRANSFER;
			rate_action_q     <= gic_pkg::RST_RATE_INSULIN_ACTION;
			rate_decay_q      <= gic_pkg::RST_RATE_INSULIN_DECAY;
			rate_absorption_q <= gic_pkg::RST_RATE_ABSORPTION;
			rate_gut_q        <= gic_pkg::RST_RATE_GUT;
			rate_emptying_q   <= gic_pkg::RST_RATE_EMPTYING;
			threshold_q       <= gic_pkg::RST_GLUCOSE_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gic_pkg::CFG_RATE_TRANSFER:       rate_transfer_q   <= cfg_data;
				gic_pkg::CFG_RATE_INSULIN_ACTION: rate_action_q     <= cfg_data;
				gic_pkg::CFG_RATE_INSULIN_DECAY:  rate_decay_q      <= cfg_data;
				gic_pkg::CFG_RATE_ABSORPTION:     rate_absorption_q <= cfg_data;
				gic_pkg::CFG_RATE_GUT:            rate_gut_q        <= cfg_data;
				gic_pkg::CFG_RATE_EMPTYING:       rate_emptying_q   <= cfg_data;
				gic_pkg::CFG_GLUCOSE_THRESHOLD:   threshold_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		m8 = item_s1.random_word[7:0];
		if (m8 >= 8'(4 * gic_pkg::MEAL_MOD))
			m8 = m8 - 8'(4 * gic_pkg::MEAL_MOD);
		if (m8 >= 8'(2 * gic_pkg::MEAL_MOD))
			m8 = m8 - 8'(2 * gic_pkg::MEAL_MOD);
		if (m8 >= 8'(gic_pkg::MEAL_MOD))
			m8 = m8 - 8'(gic_pkg::MEAL_MOD);
		grams_p = GR_W'(m8) + GR_W'(gic_pkg::MEAL_BASE);

		y1 = 15'(item_s1.random_word[31:24]) * 15'(gic_pkg::WAIT_R16)
			+ 15'(item_s1.random_word[23:16]) * 15'(gic_pkg::WAIT_R8)
			+ 15'(item_s1.random_word[15:8]);
		y2 = 11'(y1[14:8]) * 11'(gic_pkg::WAIT_R8) + 11'(y1[7:0]);
		y3 = 9'(y2[10:8]) * 9'(gic_pkg::WAIT_R8) + 9'(y2[7:0]);
		if (y3 >= 9'(2 * gic_pkg::WAIT_MOD))
			y3 = y3 - 9'(2 * gic_pkg::WAIT_MOD);
		if (y3 >= 9'(gic_pkg::WAIT_MOD))
			y3 = y3 - 9'(gic_pkg::WAIT_MOD);
		wait_p = WT_W'(y3) + WT_W'(gic_pkg::WAIT_BASE);

		dose_add_p = ADD_W'(DPW'(item_s1.dose_units) * DPW'(gic_pkg::DOSE_SCALE))
			<< (FRAC_BITS - gic_pkg::DOSE_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (item_valid)
				item_s1 <= item;
			cmd_s2      <= item_s1.command;
			grams_s2    <= grams_p;
			wait_s2     <= wait_p;
			dose_add_s2 <= dose_add_p;
		end
	end

	always_comb begin
		diff     = (plasma_glucose_q >= tissue_glucose_q) ? plasma_glucose_q - tissue_glucose_q
			: tissue_glucose_q - plasma_glucose_q;
		xfer_mag = prod(rate_transfer_q, diff);
		xfer     = (plasma_glucose_q >= tissue_glucose_q) ? sx(xfer_mag) : -sx(xfer_mag);
		act_x    = prod(rate_action_q, insulin_effect_q);
		gut_d1   = prod(rate_gut_q, gut_first_q);
		gut_d2   = prod(rate_gut_q, gut_second_q);
		dec_i    = prod(rate_decay_q, plasma_insulin_q);
		abs_s    = prod(rate_absorption_q, subcut_insulin_q);
		above    = CW'(plasma_glucose_q) > CW'({threshold_q, {FRAC_BITS{1'b0}}});
		loss     = above ? prod(rate_emptying_q, plasma_glucose_q) : '0;

		g_n = clamp(sx(plasma_glucose_q) - xfer - sx(act_x) + sx(gut_d2) - sx(loss));
		t_n = clamp(sx(tissue_glucose_q) + xfer);
		i_n = clamp(sx(plasma_insulin_q) + sx(abs_s) - sx(dec_i));
		x_n = clamp(sx(insulin_effect_q) + sx(dec_i) - sx(act_x));
		s_n = clamp(sx(subcut_insulin_q) - sx(abs_s));
		d1_tick = clamp(sx(gut_first_q) - sx(gut_d1));
		d2_n = clamp(sx(gut_second_q) + sx(gut_d1) - sx(gut_d2));

		meal_due = wait_q <= WT_W'(gic_pkg::TICK_MINUTES);
		d1_n = meal_due ? sat_add(d1_tick, ADD_W'(grams_s2) << FRAC_BITS) : d1_tick;
		s_dose = sat_add(subcut_insulin_q, dose_add_s2);

		step = en && v_s2;
		tick = cmd_s2 == gic_pkg::CMD_TICK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plasma_glucose_q <= '0;
			tissue_glucose_q <= '0;
			plasma_insulin_q <= '0;
			insulin_effect_q <= '0;
			subcut_insulin_q <= '0;
			gut_first_q      <= '0;
			gut_second_q     <= '0;
			elapsed_q        <= '0;
			wait_q           <= WT_W'(gic_pkg::WAIT_RST);
		end else if (step) begin
			if (tick) begin
				plasma_glucose_q <= g_n;
				tissue_glucose_q <= t_n;
				plasma_insulin_q <= i_n;
				insulin_effect_q <= x_n;
				subcut_insulin_q <= s_n;
				gut_first_q      <= d1_n;
				gut_second_q     <= d2_n;
				elapsed_q        <= elapsed_q + EL_W'(gic_pkg::TICK_MINUTES);
				wait_q           <= meal_due ? wait_s2 : wait_q - WT_W'(gic_pkg::TICK_MINUTES);
			end else begin
				subcut_insulin_q <= s_dose;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			grams_s3 <= (tick && meal_due) ? grams_s2 : '0;
	end

	assign mmol_ctl.en                = en;
	assign mmol_ctl.valid             = v_s3;
	assign mmol_side.meal_grams       = grams_s3;
	assign mmol_side.elapsed_minutes  = elapsed_q;

	gic_mmol_pipe #(
		.STATE_WIDTH (STATE_WIDTH)
	) u_mmol (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (mmol_ctl),
		.glucose      (plasma_glucose_q),
		.side         (mmol_side),
		.result_valid (result_valid),
		.result       (result)
	);

	`GIC_ASSERT_NXT(a_tick_advances_time, step && tick,
		elapsed_q == $past(elapsed_q) + EL_W'(gic_pkg::TICK_MINUTES),
		"tick did not advance elapsed time by one step")
	`GIC_ASSERT_IMP(a_meal_wait_range, 1'b1,
		wait_q != '0 && wait_q <= WT_W'(gic_pkg::WAIT_BASE + gic_pkg::WAIT_MOD - 1),
		"meal wait out of range")
	`GIC_ASSERT_IMP(a_stall_only_on_full_output, item_stall,
		result_valid && result_stall,
		"item stalled while output register free")

endmodule

### tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 6;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REG_COUNT = int'(gic_pkg::CFG_GLUCOSE_THRESHOLD) + 1;
	localparam logic [gic_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
	localparam int FRAC = gic_pkg::DEF_FRAC_BITS;
	localparam longint unsigned LEVEL_TOP = (64'd1 << gic_pkg::DEF_STATE_WIDTH) - 64'd1;
	localparam longint unsigned MMOL_TOP = (64'd1 << gic_pkg::MMOL_W) - 64'd1;

	typedef logic [gic_pkg::DEF_STATE_WIDTH-1:0] level_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	gic_pkg::in_item_t item;
	logic result_valid;
	logic result_stall;
	gic_pkg::out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [gic_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gic_pkg::CFG_DATA_W-1:0] cfg_data;

	glucose_insulin_compartment_step_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [gic_pkg::CFG_DATA_W-1:0] coef [REG_COUNT];
	logic [gic_pkg::CFG_DATA_W-1:0] setting [REG_COUNT];
	level_t g_plasma, g_tissue, i_plasma, i_effect, i_subcut, gut_a, gut_b;
	logic [gic_pkg::ELAPSED_W-1:0] minutes;
	logic [gic_pkg::WAIT_W-1:0] meal_wait;

	gic_pkg::out_item_t pending_readings [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit tx_no_idle = 1'b0;
	bit rx_no_idle = 1'b0;
	bit hold_off_req = 1'b0;

	function automatic longint rated(input logic [gic_pkg::CFG_DATA_W-1:0] r,
			input longint unsigned x);
		longint unsigned p;
		p = 64'(r) * x;
		return longint'(p >> 16);
	endfunction

	function automatic level_t clip(input longint v);
		if (v < 0)
			return '0;
		if (v > longint'(LEVEL_TOP))
			return level_t'(LEVEL_TOP);
		return level_t'(v);
	endfunction

	function automatic gic_pkg::out_item_t predict_reading(input gic_pkg::in_item_t it);
		longint g, t, i, x, s, d1, d2;
		longint xfer, act_x, gut_d1, gut_d2, dec_i, abs_s, loss;
		logic [gic_pkg::GRAMS_W-1:0] grams;
		longint unsigned mmol;
		gic_pkg::out_item_t r;
		grams = '0;
		if (it.command == gic_pkg::CMD_TICK) begin
			g = longint'(g_plasma);
			t = longint'(g_tissue);
			i = longint'(i_plasma);
			x = longint'(i_effect);
			s = longint'(i_subcut);
			d1 = longint'(gut_a);
			d2 = longint'(gut_b);
			if (g >= t)
				xfer = rated(coef[gic_pkg::CFG_RATE_TRANSFER], g - t);
			else
				xfer = -rated(coef[gic_pkg::CFG_RATE_TRANSFER], t - g);
			act_x = rated(coef[gic_pkg::CFG_RATE_INSULIN_ACTION], x);
			gut_d1 = rated(coef[gic_pkg::CFG_RATE_GUT], d1);
			gut_d2 = rated(coef[gic_pkg::CFG_RATE_GUT], d2);
			dec_i = rated(coef[gic_pkg::CFG_RATE_INSULIN_DECAY], i);
			abs_s = rated(coef[gic_pkg::CFG_RATE_ABSORPTION], s);
			loss = 0;
			if (g > (longint'(coef[gic_pkg::CFG_GLUCOSE_THRESHOLD]) << FRAC))
				loss = rated(coef[gic_pkg::CFG_RATE_EMPTYING], g);
			g_plasma = clip(g - xfer - act_x + gut_d2 - loss);
			g_tissue = clip(t + xfer);
			i_plasma = clip(i + abs_s - dec_i);
			i_effect = clip(x + dec_i - act_x);
			i_subcut = clip(s - abs_s);
			gut_a = clip(d1 - gut_d1);
			gut_b = clip(d2 + gut_d1 - gut_d2);
			minutes = gic_pkg::ELAPSED_W'(minutes + gic_pkg::TICK_MINUTES);
			if (meal_wait > gic_pkg::TICK_MINUTES) begin
				meal_wait = gic_pkg::WAIT_W'(meal_wait - gic_pkg::TICK_MINUTES);
			end else begin
				grams = gic_pkg::GRAMS_W'(it.random_word[7:0] % gic_pkg::MEAL_MOD
					+ gic_pkg::MEAL_BASE);
				gut_a = clip(longint'(gut_a) + (longint'(grams) << FRAC));
				meal_wait = gic_pkg::WAIT_W'(it.random_word[gic_pkg::RND_W-1:8]
					% gic_pkg::WAIT_MOD + gic_pkg::WAIT_BASE);
			end
		end else begin
			i_subcut = clip(longint'(i_subcut)
				+ ((longint'(it.dose_units) * gic_pkg::DOSE_SCALE)
				<< (FRAC - gic_pkg::DOSE_FRAC)));
		end
		mmol = (64'(g_plasma) * 64'(gic_pkg::MMOL_MUL)) / 64'(gic_pkg::MMOL_DIV);
		if (mmol > MMOL_TOP)
			mmol = MMOL_TOP;
		r.glucose_mmol = gic_pkg::MMOL_W'(mmol);
		r.meal_grams = grams;
		r.elapsed_minutes = minutes;
		return r;
	endfunction

	function automatic gic_pkg::in_item_t random_item();
		gic_pkg::in_item_t it;
		int pick;
		it.command = ($urandom_range(99) < 20) ? gic_pkg::CMD_DOSE : gic_pkg::CMD_TICK;
		it.random_word = $urandom();
		pick = $urandom_range(99);
		if (pick < 60)
			it.dose_units = gic_pkg::DOSE_W'($urandom_range(31));
		else if (pick < 85)
			it.dose_units = gic_pkg::DOSE_W'($urandom_range(1023));
		else
			it.dose_units = gic_pkg::DOSE_W'($urandom());
		return it;
	endfunction

	task automatic send_item(input gic_pkg::in_item_t it);
		if (!tx_no_idle && $urandom_range(99) < 35) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_readings.push_back(predict_reading(it));
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic program_regs();
		settle();
		for (int k = 0; k < REG_COUNT; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= gic_pkg::cfg_reg_t'(k);
			cfg_data <= setting[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			coef[k] = setting[k];
		end
		// unknown index, must be dropped
		cfg_index <= CFG_IDX_SPARE;
		cfg_data <= gic_pkg::CFG_DATA_W'($urandom());
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		gic_pkg::in_item_t it;
		it = '0;
		it.command = gic_pkg::CMD_TICK;
		repeat (3) send_item(it);
		// largest meal, longest wait
		it.random_word = 32'h0000_7837;
		send_item(it);
		it.command = gic_pkg::CMD_DOSE;
		it.dose_units = '0;
		it.random_word = '1;
		send_item(it);
		it.dose_units = '1;
		repeat (6) send_item(it);
		it.dose_units = 16'h0001;
		send_item(it);
		it.command = gic_pkg::CMD_TICK;
		it.dose_units = '1;
		repeat (10) send_item(it);
	endtask

	task automatic test_full_rate();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		repeat (200) send_item(random_item());
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_off_req = 1'b1;
		tx_no_idle = 1'b1;
		repeat (120) send_item(random_item());
		tx_no_idle = 1'b0;
	endtask

	task automatic test_register_extremes(input logic [gic_pkg::CFG_DATA_W-1:0] level);
		foreach (setting[k]) setting[k] = level;
		program_regs();
		repeat (150) send_item(random_item());
	endtask

	task automatic test_insulin_saturation();
		gic_pkg::in_item_t it;
		foreach (setting[k]) setting[k] = gic_pkg::CFG_DATA_W'($urandom());
		setting[gic_pkg::CFG_RATE_INSULIN_ACTION] = '0;
		setting[gic_pkg::CFG_RATE_INSULIN_DECAY] = '0;
		setting[gic_pkg::CFG_RATE_ABSORPTION] = '1;
		setting[gic_pkg::CFG_GLUCOSE_THRESHOLD] = '0;
		program_regs();
		repeat (150) begin
			it = random_item();
			if ($urandom_range(1)) begin
				it.command = gic_pkg::CMD_DOSE;
				it.dose_units = '1;
			end
			send_item(it);
		end
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 4; p++) begin
			foreach (setting[k]) setting[k] = gic_pkg::CFG_DATA_W'($urandom());
			if (p % 2 == 1)
				setting[gic_pkg::CFG_GLUCOSE_THRESHOLD] =
					gic_pkg::CFG_DATA_W'($urandom_range(40));
			program_regs();
			repeat (240) send_item(random_item());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		coef[gic_pkg::CFG_RATE_TRANSFER] = gic_pkg::RST_RATE_TRANSFER;
		coef[gic_pkg::CFG_RATE_INSULIN_ACTION] = gic_pkg::RST_RATE_INSULIN_ACTION;
		coef[gic_pkg::CFG_RATE_INSULIN_DECAY] = gic_pkg::RST_RATE_INSULIN_DECAY;
		coef[gic_pkg::CFG_RATE_ABSORPTION] = gic_pkg::RST_RATE_ABSORPTION;
		coef[gic_pkg::CFG_RATE_GUT] = gic_pkg::RST_RATE_GUT;
		coef[gic_pkg::CFG_RATE_EMPTYING] = gic_pkg::RST_RATE_EMPTYING;
		coef[gic_pkg::CFG_GLUCOSE_THRESHOLD] = gic_pkg::RST_GLUCOSE_THRESHOLD;
		{g_plasma, g_tissue, i_plasma, i_effect, i_subcut, gut_a, gut_b} = '0;
		minutes = '0;
		meal_wait = gic_pkg::WAIT_W'(gic_pkg::WAIT_RST);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rate();
		test_backpressure();
		test_register_extremes('0);
		test_insulin_saturation();
		test_register_extremes('1);
		test_random_settings();
		settle();
		repeat (PIPE_LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("[glucose_insulin_compartment_step_unit] OK");
		else
			$display("[glucose_insulin_compartment_step_unit] ERROR");
		$finish;
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			result_stall <= !rx_no_idle && ($urandom_range(99) < 35);
		end
	end

	always @(posedge clk) begin : check_readings
		gic_pkg::out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected reading: mmol=%0d grams=%0d minutes=%0d",
						result.glucose_mmol, result.meal_grams, result.elapsed_minutes);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (result.glucose_mmol !== want.glucose_mmol
						|| result.meal_grams !== want.meal_grams
						|| result.elapsed_minutes !== want.elapsed_minutes) begin
					if (mismatches < 10)
						$display({"reading mismatch: expected mmol=%0d grams=%0d minutes=%0d,",
							" got mmol=%0d grams=%0d minutes=%0d"},
							want.glucose_mmol, want.meal_grams, want.elapsed_minutes,
							result.glucose_mmol, result.meal_grams, result.elapsed_minutes);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[glucose_insulin_compartment_step_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
